FILE: hdl/imhu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imhu_pkg
// Shared types, constants and micro-op decode for the integer mix hash unit.
// ----------------------------------------------------------------------------
package imhu_pkg;

    localparam int NUM_CELLS = 23;
    localparam int PC_W      = 5;
    localparam int LATE_PC   = 16;

    localparam logic [63:0] FIN_SEED = 64'd61;
    localparam logic [31:0] MIX_P8   = 32'h0000_009D;
    localparam logic [31:0] MIX_P16  = 32'h0000_9E37;
    localparam logic [31:0] FIN_K32  = 32'h27D4_EB2D;
    localparam logic [31:0] MIX_P32  = 32'h9E37_79B9;
    localparam logic [63:0] MIX_P64  = 64'h9E37_79B9_7F4A_7C15;

    typedef enum logic [1:0] {
        CMD_SINGLE = 2'd0,
        CMD_PACK   = 2'd1,
        CMD_MIX    = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        WS_8  = 2'd0,
        WS_16 = 2'd1,
        WS_32 = 2'd2,
        WS_64 = 2'd3
    } ws_t;

    typedef enum logic [3:0] {
        UOP_F1,
        UOP_F2,
        UOP_F3,
        UOP_F4,
        UOP_F5,
        UOP_F6,
        UOP_F7,
        UOP_M1,
        UOP_M2,
        UOP_M3,
        UOP_NOP
    } uop_t;

    typedef struct packed {
        uop_t op;
        logic late;      // second finalizer pass, mix command only
    } uop_sel_t;

    // Work item handed from cell to cell
    typedef struct packed {
        logic [PC_W-1:0] pc;
        ws_t             ws;
        logic            mix_on;
        logic [1:0]      mix_left;
        logic [63:0]     h;
        logic [63:0]     aux;
        logic [63:0]     opb;
        logic [63:0]     opc;
        logic [63:0]     opd;
    } item_t;

    function automatic logic [63:0] width_mask(input ws_t ws);
        logic [63:0] m;
        unique case (ws)
            WS_8:    m = 64'h0000_0000_0000_00FF;
            WS_16:   m = 64'h0000_0000_0000_FFFF;
            WS_32:   m = 64'h0000_0000_FFFF_FFFF;
            WS_64:   m = 64'hFFFF_FFFF_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // Program: finalizer, three mix rounds of three steps, finalizer again
    function automatic uop_sel_t uop_of(input logic [PC_W-1:0] pc);
        uop_sel_t s;
        s.late = (pc >= PC_W'(LATE_PC));
        unique case (pc) inside
            5'd0, 5'd16:        s.op = UOP_F1;
            5'd1, 5'd17:        s.op = UOP_F2;
            5'd2, 5'd18:        s.op = UOP_F3;
            5'd3, 5'd19:        s.op = UOP_F4;
            5'd4, 5'd20:        s.op = UOP_F5;
            5'd5, 5'd21:        s.op = UOP_F6;
            5'd6, 5'd22:        s.op = UOP_F7;
            5'd7, 5'd10, 5'd13: s.op = UOP_M1;
            5'd8, 5'd11, 5'd14: s.op = UOP_M2;
            5'd9, 5'd12, 5'd15: s.op = UOP_M3;
            default:            s.op = UOP_NOP;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/imhu_load.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imhu_load
// Turns one input beat into the first work item: masks, folds signed zero,
// packs operand slices and sets up the mix round count.
// ----------------------------------------------------------------------------
module imhu_load (
    input  logic [1:0]      command,
    input  logic [2:0]      operand_count,
    input  logic [1:0]      word_size,
    input  logic            float_mode,
    input  logic [63:0]     op_a,
    input  logic [63:0]     op_b,
    input  logic [63:0]     op_c,
    input  logic [63:0]     op_d,
    output imhu_pkg::item_t item
);
    import imhu_pkg::*;

    ws_t         ws;
    logic [63:0] mask;
    logic [2:0]  n;
    logic        fold_en;
    logic [63:0] a, b, c, d;
    logic [63:0] packed_word;

    function automatic logic [63:0] fold_zero(input ws_t w, input logic fe,
                                              input logic [63:0] v);
        logic [63:0] r;
        r = v;
        if (fe && w == WS_32 && v[30:0] == 31'd0)
            r[31] = 1'b0;
        else if (fe && w == WS_64 && v[62:0] == 63'd0)
            r = 64'd0;
        return r;
    endfunction

    always_comb
    begin
        ws      = ws_t'(word_size);
        mask    = width_mask(ws);
        fold_en = float_mode && (command != CMD_PACK);
        a       = op_a & mask;
        b       = op_b & mask;
        c       = op_c & mask;
        d       = op_d & mask;

        if (operand_count < 3'd2)
            n = 3'd2;
        else if (operand_count > 3'd4)
            n = 3'd4;
        else
            n = operand_count;

        // op_a in the lowest slice
        packed_word = 64'd0;
        unique case (ws)
            WS_8:
            begin
                if (n == 3'd2)
                    packed_word = {56'd0, b[3:0], a[3:0]};
                else if (n == 3'd3)
                    packed_word = {56'd0, c[1:0], b[2:0], a[2:0]};
                else
                    packed_word = {56'd0, d[1:0], c[1:0], b[1:0], a[1:0]};
            end
            WS_16:
            begin
                if (n == 3'd2)
                    packed_word = {48'd0, b[7:0], a[7:0]};
                else if (n == 3'd3)
                    packed_word = {49'd0, c[4:0], b[4:0], a[4:0]};
                else
                    packed_word = {48'd0, d[3:0], c[3:0], b[3:0], a[3:0]};
            end
            WS_32:
            begin
                if (n == 3'd2)
                    packed_word = {32'd0, b[15:0], a[15:0]};
                else if (n == 3'd3)
                    packed_word = {34'd0, c[9:0], b[9:0], a[9:0]};
                else
                    packed_word = {32'd0, d[7:0], c[7:0], b[7:0], a[7:0]};
            end
            WS_64:
            begin
                if (n == 3'd2)
                    packed_word = {b[31:0], a[31:0]};
                else if (n == 3'd3)
                    packed_word = {1'b0, c[20:0], b[20:0], a[20:0]};
                else
                    packed_word = {d[15:0], c[15:0], b[15:0], a[15:0]};
            end
            default: packed_word = 64'd0;
        endcase

        item.pc       = '0;
        item.ws       = ws;
        item.mix_on   = (command == CMD_MIX);
        item.mix_left = (command == CMD_MIX) ? 2'(n - 3'd1) : 2'd0;
        item.h        = (command == CMD_PACK) ? packed_word : fold_zero(ws, fold_en, a);
        item.aux      = 64'd0;
        item.opb      = fold_zero(ws, fold_en, b);
        item.opc      = fold_zero(ws, fold_en, c);
        item.opd      = fold_zero(ws, fold_en, d);
    end

endmodule
`default_nettype wire

FILE: hdl/imhu_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imhu_cell
// One step of the hash program: decodes the item's pc, runs one finalizer or
// mix step on a shared 32x32 multiplier and adders, registers the result.
// ----------------------------------------------------------------------------
module imhu_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  imhu_pkg::item_t in_item,
    output logic            out_valid,
    output imhu_pkg::item_t out_item
);
    import imhu_pkg::*;

    uop_sel_t    sel;
    logic [63:0] mask;
    logic [63:0] h;
    logic [63:0] x;
    logic [4:0]  s1, s3, s5;
    logic [31:0] k_fin, p_lo, p_hi;
    logic        fin_on;
    logic        mix_on;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    item_t       item_next;
    logic        valid_reg;
    item_t       item_reg;

    always_comb
    begin
        sel    = uop_of(in_item.pc);
        mask   = width_mask(in_item.ws);
        h      = in_item.h;
        x      = in_item.h ^ in_item.opb;
        fin_on = !sel.late || in_item.mix_on;
        mix_on = (in_item.mix_left != 2'd0);

        unique case (in_item.ws)
            WS_8:
            begin
                s1 = 5'd4;  s3 = 5'd3; s5 = 5'd4;
                k_fin = MIX_P8;  p_lo = MIX_P8;  p_hi = 32'd0;
            end
            WS_16:
            begin
                s1 = 5'd8;  s3 = 5'd4; s5 = 5'd8;
                k_fin = MIX_P16; p_lo = MIX_P16; p_hi = 32'd0;
            end
            WS_32:
            begin
                s1 = 5'd16; s3 = 5'd4; s5 = 5'd15;
                k_fin = FIN_K32; p_lo = MIX_P32; p_hi = 32'd0;
            end
            default:
            begin
                s1 = 5'd16; s3 = 5'd4; s5 = 5'd15;
                k_fin = FIN_K32; p_lo = MIX_P64[31:0]; p_hi = MIX_P64[63:32];
            end
        endcase
    end

    // 64-bit mix product built from low x low, then the two cross terms
    always_comb
    begin
        mul_a = h[31:0];
        mul_b = k_fin;
        unique case (sel.op)
            UOP_M1:
            begin
                mul_a = x[31:0];
                mul_b = p_lo;
            end
            UOP_M2:
            begin
                mul_a = h[63:32];
                mul_b = p_lo;
            end
            UOP_M3:
            begin
                mul_a = h[31:0];
                mul_b = p_hi;
            end
            default:
            begin
                mul_a = h[31:0];
                mul_b = k_fin;
            end
        endcase
    end

    assign prod = {32'd0, mul_a} * {32'd0, mul_b};

    always_comb
    begin
        item_next    = in_item;
        item_next.pc = in_item.pc + PC_W'(1);
        unique case (sel.op)
            UOP_F1:
                if (fin_on)
                begin
                    if (in_item.ws == WS_64)
                        item_next.h = ~h + (h << 21);
                    else
                        item_next.h = ((h ^ FIN_SEED) ^ (h >> s1)) & mask;
                end
            UOP_F2:
                if (fin_on)
                begin
                    if (in_item.ws == WS_64)
                        item_next.h = h ^ (h >> 24);
                    else
                        item_next.h = (h + (h << 3)) & mask;
                end
            UOP_F3:
                if (fin_on)
                begin
                    if (in_item.ws == WS_64)
                        item_next.h = h + (h << 3) + (h << 8);
                    else
                        item_next.h = h ^ (h >> s3);
                end
            UOP_F4:
                if (fin_on)
                begin
                    if (in_item.ws == WS_64)
                        item_next.h = h ^ (h >> 14);
                    else
                        item_next.h = {32'd0, prod[31:0]} & mask;
                end
            UOP_F5:
                if (fin_on)
                begin
                    if (in_item.ws == WS_64)
                        item_next.h = h + (h << 4) + (h << 13);
                    else
                        item_next.h = h ^ (h >> s5);
                end
            UOP_F6:
                if (fin_on && in_item.ws == WS_64)
                    item_next.h = h ^ (h >> 28);
            UOP_F7:
                if (fin_on && in_item.ws == WS_64)
                    item_next.h = h + (h << 31);
            UOP_M1:
                if (mix_on)
                begin
                    item_next.h   = x;
                    item_next.aux = prod;
                end
            UOP_M2:
                if (mix_on)
                    item_next.aux = in_item.aux + {prod[31:0], 32'd0};
            UOP_M3:
                if (mix_on)
                begin
                    item_next.h        = (in_item.aux + {prod[31:0], 32'd0}) & mask;
                    item_next.opb      = in_item.opc;
                    item_next.opc      = in_item.opd;
                    item_next.mix_left = in_item.mix_left - 2'd1;
                end
            default:
                item_next = in_item;
        endcase
        if (sel.op == UOP_NOP)
            item_next.pc = in_item.pc + PC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

FILE: hdl/integer_mix_hash_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_mix_hash_unit
// Pipelined 8/16/32/64-bit integer hash: single, pack and multiply-mix modes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one beat per cycle while
//   in_ready is high: command, operand_count, word_size, float_mode and
//   op_a..op_d. Output channel (out_valid/out_ready) returns one hash_value
//   beat per input beat, in order. A beat passes through 23 chained cells,
//   one program step each, and then the output register. Throughput is one
//   beat per cycle, set by the cell chain which advances every cycle the
//   output register is free.
//   When the receiver stalls, the chain freezes and one more input beat is
//   parked in a skid register; in_ready drops only while that register is
//   full, so in_ready is a plain register output.
//   Reset clears all valid flags: no beats in flight, in_ready high.
//   Each cell holds one 32x32 multiplier; a 64-bit mix multiply spans three
//   cells (low product, then the two cross terms).
// ----------------------------------------------------------------------------
module integer_mix_hash_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [2:0]  operand_count,
    input  logic [1:0]  word_size,
    input  logic        float_mode,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    input  logic [63:0] op_c,
    input  logic [63:0] op_d,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] hash_value
);
    import imhu_pkg::*;

    logic        en;
    logic        in_accept;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    logic [1:0]  skid_command_reg;
    logic [2:0]  skid_count_reg;
    logic [1:0]  skid_ws_reg;
    logic        skid_fm_reg;
    logic [63:0] skid_a_reg, skid_b_reg, skid_c_reg, skid_d_reg;

    logic [1:0]  src_command;
    logic [2:0]  src_count;
    logic [1:0]  src_ws;
    logic        src_fm;
    logic [63:0] src_a, src_b, src_c, src_d;

    logic [NUM_CELLS:0] chain_valid;
    item_t              chain_item [0:NUM_CELLS];

    logic        out_valid_reg;
    logic [63:0] hash_reg;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = !skid_valid_reg;
    assign in_accept = in_valid && in_ready;

    // parked beat goes first
    always_comb
    begin
        if (skid_valid_reg)
        begin
            src_command = skid_command_reg;
            src_count   = skid_count_reg;
            src_ws      = skid_ws_reg;
            src_fm      = skid_fm_reg;
            src_a       = skid_a_reg;
            src_b       = skid_b_reg;
            src_c       = skid_c_reg;
            src_d       = skid_d_reg;
        end
        else
        begin
            src_command = command;
            src_count   = operand_count;
            src_ws      = word_size;
            src_fm      = float_mode;
            src_a       = op_a;
            src_b       = op_b;
            src_c       = op_c;
            src_d       = op_d;
        end
        skid_valid_next = en ? 1'b0 : (skid_valid_reg || in_accept);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_valid_reg <= 1'b0;
        else
            skid_valid_reg <= skid_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && !en)
        begin
            skid_command_reg <= command;
            skid_count_reg   <= operand_count;
            skid_ws_reg      <= word_size;
            skid_fm_reg      <= float_mode;
            skid_a_reg       <= op_a;
            skid_b_reg       <= op_b;
            skid_c_reg       <= op_c;
            skid_d_reg       <= op_d;
        end
    end

    assign chain_valid[0] = skid_valid_reg || in_valid;

    imhu_load u_load (
        .command       (src_command),
        .operand_count (src_count),
        .word_size     (src_ws),
        .float_mode    (src_fm),
        .op_a          (src_a),
        .op_b          (src_b),
        .op_c          (src_c),
        .op_d          (src_d),
        .item          (chain_item[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        imhu_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_item   (chain_item[i]),
            .out_valid (chain_valid[i+1]),
            .out_item  (chain_item[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= chain_valid[NUM_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            hash_reg <= chain_item[NUM_CELLS].h;
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && en |=> !skid_valid_reg)
        else $error("skid beat not drained while chain advanced");

    a_mix_done: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[NUM_CELLS] |-> chain_item[NUM_CELLS].mix_left == 2'd0)
        else $error("mix rounds left at end of chain");

    a_narrow_masked: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[NUM_CELLS] && chain_item[NUM_CELLS].ws != WS_64
        |-> chain_item[NUM_CELLS].h[63:32] == 32'd0)
        else $error("narrow hash has bits above its width");

endmodule
`default_nettype wire

FILE: tb/integer_mix_hash_unit_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_mix_hash_unit_test
// Self-checking bench for the integer mix hash unit. A directed table covers
// word-size extremes, the signed-zero fold, pack slicing, operand count
// clamping and the spare command code; random beats follow. Every accepted
// beat without a typed-in expectation is hashed by an in-bench predictor;
// all are compared, in order, with the returned hash_value. Both handshakes
// idle at random, with one long output hold-off that backs the pipe up.
// ----------------------------------------------------------------------------
module integer_mix_hash_unit_test;

    import imhu_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;     // decodes as single hash
    localparam int RANDOM_BEATS   = 600;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 400_000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  count;
        logic [1:0]  ws;
        logic        fm;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        logic        typed;
        logic [63:0] want;
    } beat_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = '0;
    logic [2:0]  operand_count = '0;
    logic [1:0]  word_size = '0;
    logic        float_mode = 1'b0;
    logic [63:0] op_a = '0;
    logic [63:0] op_b = '0;
    logic [63:0] op_c = '0;
    logic [63:0] op_d = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] hash_value;

    // typed-in expectation riding along with the current input beat
    logic        typed_on = 1'b0;
    logic [63:0] typed_want = '0;

    logic [63:0] pending_hashes [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;

    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int          stall_left = 0;
    logic        rx_calm = 1'b0;
    int unsigned rx_pick;

    // Fold and slice rows are checked by the predictor; zero at 8 and 16 bits
    // finalizes to 0x3E and 0xC140, typed in.
    beat_row_t directed_rows [25] = '{
        '{CMD_SINGLE, 3'd2, WS_8,  1'b0, 64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 64'h3E},
        '{CMD_SINGLE, 3'd2, WS_8,  1'b1, 64'hFFFF_FFFF_FFFF_FF00, 64'h0, 64'h0, 64'h0,
          1'b1, 64'h3E},
        '{CMD_SINGLE, 3'd0, WS_16, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 64'hC140},
        '{CMD_SINGLE, 3'd7, WS_16, 1'b1, 64'hFFFF_FFFF_FFFF_0000, 64'h1, 64'h2, 64'h3,
          1'b1, 64'hC140},
        '{CMD_SINGLE, 3'd2, WS_16, 1'b1, 64'h8000, 64'h0, 64'h0, 64'h0, 1'b0, 64'h0},
        '{CMD_SINGLE, 3'd2, WS_32, 1'b0, 64'hFFFF_FFFF, 64'h0, 64'h0, 64'h0, 1'b0, 64'h0},
        '{CMD_SINGLE, 3'd2, WS_32, 1'b1, 64'hFFFF_FFFF_8000_0000, 64'h0, 64'h0, 64'h0,
          1'b0, 64'h0},
        '{CMD_SINGLE, 3'd2, WS_32, 1'b0, 64'h8000_0000, 64'h0, 64'h0, 64'h0, 1'b0, 64'h0},
        '{CMD_SINGLE, 3'd2, WS_64, 1'b0, '1, '1, '1, '1, 1'b0, 64'h0},
        '{CMD_SINGLE, 3'd2, WS_64, 1'b0, 64'h0, 64'h0, 64'h0, 64'h0, 1'b0, 64'h0},
        '{CMD_SINGLE, 3'd2, WS_64, 1'b1, 64'h8000_0000_0000_0000, 64'h0, 64'h0, 64'h0,
          1'b0, 64'h0},
        '{CMD_SPARE,  3'd4, WS_32, 1'b0, 64'h1234_5678_9ABC_DEF0, 64'h5, 64'h6, 64'h7,
          1'b0, 64'h0},
        '{CMD_PACK,   3'd2, WS_8,  1'b0, '1, '1, '1, '1, 1'b0, 64'h0},
        '{CMD_PACK,   3'd3, WS_8,  1'b0, '1, '1, '1, '1, 1'b0, 64'h0},
        '{CMD_PACK,   3'd4, WS_8,  1'b0, 64'h1, 64'h2, 64'h3, 64'hA5, 1'b0, 64'h0},
        '{CMD_PACK,   3'd2, WS_16, 1'b0, '1, '1, '1, '1, 1'b0, 64'h0},
        '{CMD_PACK,   3'd3, WS_32, 1'b0, '1, '1, '1, '1, 1'b0, 64'h0},
        '{CMD_PACK,   3'd4, WS_32, 1'b1, 64'h8000_0000, 64'h8000_0000, 64'h8000_0000,
          64'h8000_0000, 1'b0, 64'h0},
        '{CMD_PACK,   3'd3, WS_64, 1'b0, '1, '1, '1, '1, 1'b0, 64'h0},
        '{CMD_PACK,   3'd4, WS_64, 1'b0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
          64'h0F0F_F0F0_3C3C_C3C3, 64'hDEAD_BEEF_0000_FFFF, 1'b0, 64'h0},
        '{CMD_MIX,    3'd0, WS_8,  1'b0, 64'hFF, 64'hFF, 64'hFF, 64'hFF, 1'b0, 64'h0},
        '{CMD_MIX,    3'd7, WS_16, 1'b0, '1, '1, '1, '1, 1'b0, 64'h0},
        '{CMD_MIX,    3'd4, WS_32, 1'b1, 64'h8000_0000, 64'h8000_0000, 64'h8000_0000,
          64'h8000_0000, 1'b0, 64'h0},
        '{CMD_MIX,    3'd3, WS_64, 1'b1, 64'h0, 64'h8000_0000_0000_0000, 64'h1, '1,
          1'b0, 64'h0},
        '{CMD_MIX,    3'd2, WS_64, 1'b0, '1, '1, '1, '1, 1'b0, 64'h0}
    };

    integer_mix_hash_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .operand_count (operand_count),
        .word_size     (word_size),
        .float_mode    (float_mode),
        .op_a          (op_a),
        .op_b          (op_b),
        .op_c          (op_c),
        .op_d          (op_d),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hash_value    (hash_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Hash predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] word_mask(input ws_t ws);
        logic [63:0] m;
        case (ws)
            WS_8:    m = 64'hFF;
            WS_16:   m = 64'hFFFF;
            WS_32:   m = 64'hFFFF_FFFF;
            default: m = '1;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] finalize_word(input ws_t ws, input logic [63:0] x);
        logic [7:0]  h8;
        logic [15:0] h16;
        logic [31:0] h32;
        logic [63:0] h64;
        logic [63:0] r;
        h8  = x[7:0];
        h16 = x[15:0];
        h32 = x[31:0];
        h64 = x;
        case (ws)
            WS_8:
            begin
                h8 = (h8 ^ 8'd61) ^ (h8 >> 4);
                h8 = h8 + (h8 << 3);
                h8 = h8 ^ (h8 >> 3);
                h8 = h8 * MIX_P8[7:0];
                h8 = h8 ^ (h8 >> 4);
                r = {56'd0, h8};
            end
            WS_16:
            begin
                h16 = (h16 ^ 16'd61) ^ (h16 >> 8);
                h16 = h16 + (h16 << 3);
                h16 = h16 ^ (h16 >> 4);
                h16 = h16 * MIX_P16[15:0];
                h16 = h16 ^ (h16 >> 8);
                r = {48'd0, h16};
            end
            WS_32:
            begin
                h32 = (h32 ^ 32'd61) ^ (h32 >> 16);
                h32 = h32 + (h32 << 3);
                h32 = h32 ^ (h32 >> 4);
                h32 = h32 * FIN_K32;
                h32 = h32 ^ (h32 >> 15);
                r = {32'd0, h32};
            end
            default:
            begin
                h64 = ~h64 + (h64 << 21);
                h64 = h64 ^ (h64 >> 24);
                h64 = h64 + (h64 << 3) + (h64 << 8);
                h64 = h64 ^ (h64 >> 14);
                h64 = h64 + (h64 << 4) + (h64 << 13);
                h64 = h64 ^ (h64 >> 28);
                h64 = h64 + (h64 << 31);
                r = h64;
            end
        endcase
        return r;
    endfunction

    // float mode: negative zero becomes positive zero at 32 and 64 bits
    function automatic logic [63:0] fold_neg_zero(input ws_t ws, input logic fm,
                                                  input logic [63:0] x);
        logic [63:0] r;
        r = x;
        if (fm && ws == WS_32 && x[30:0] == '0)
            r[31] = 1'b0;
        if (fm && ws == WS_64 && x[62:0] == '0)
            r = '0;
        return r;
    endfunction

    function automatic logic [63:0] pack_slices(input ws_t ws, input int n,
                                                input logic [63:0] a, input logic [63:0] b,
                                                input logic [63:0] c, input logic [63:0] d);
        logic [63:0] ops [4];
        logic [63:0] word;
        int          w;
        int          wi;
        int          pos;
        ops[0] = a;
        ops[1] = b;
        ops[2] = c;
        ops[3] = d;
        case (ws)
            WS_8:    w = (n == 2) ? 4  : (n == 3) ? 3  : 2;
            WS_16:   w = (n == 2) ? 8  : (n == 3) ? 5  : 4;
            WS_32:   w = (n == 2) ? 16 : (n == 3) ? 10 : 8;
            default: w = (n == 2) ? 32 : (n == 3) ? 21 : 16;
        endcase
        word = '0;
        pos = 0;
        for (int i = 0; i < n; i++)
        begin
            // 3+3+2 at 8 bits: last slice is narrower
            wi = (ws == WS_8 && n == 3 && i == 2) ? 2 : w;
            word = word | ((ops[i] & ((64'd1 << wi) - 64'd1)) << pos);
            pos = pos + wi;
        end
        return word & word_mask(ws);
    endfunction

    function automatic logic [63:0] expected_hash(input logic [1:0] cmd,
                                                  input logic [2:0] count, input ws_t ws,
                                                  input logic fm,
                                                  input logic [63:0] a, input logic [63:0] b,
                                                  input logic [63:0] c, input logic [63:0] d);
        logic [63:0] m;
        logic [63:0] ops [4];
        logic [63:0] prime;
        logic [63:0] h;
        int          n;
        m = word_mask(ws);
        ops[0] = a & m;
        ops[1] = b & m;
        ops[2] = c & m;
        ops[3] = d & m;
        n = (count < 3'd2) ? 2 : (count > 3'd4) ? 4 : int'(count);
        case (ws)
            WS_8:    prime = {32'd0, MIX_P8};
            WS_16:   prime = {32'd0, MIX_P16};
            WS_32:   prime = {32'd0, MIX_P32};
            default: prime = MIX_P64;
        endcase
        if (cmd == CMD_PACK)
        begin
            h = finalize_word(ws, pack_slices(ws, n, ops[0], ops[1], ops[2], ops[3]));
        end
        else if (cmd == CMD_MIX)
        begin
            h = finalize_word(ws, fold_neg_zero(ws, fm, ops[0]));
            for (int i = 1; i < n; i++)
                h = ((h ^ fold_neg_zero(ws, fm, ops[i])) * prime) & m;
            h = finalize_word(ws, h);
        end
        else
        begin
            h = finalize_word(ws, fold_neg_zero(ws, fm, ops[0]));
        end
        return h & m;
    endfunction

    // ------------------------------------------------------------------
    // Random beats
    // ------------------------------------------------------------------
    function automatic logic [63:0] random_operand(input logic [1:0] ws);
        int unsigned pick;
        logic [63:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            v = {$urandom, $urandom};
        else if (pick < 63)
            v = '0;
        else if (pick < 71)
            v = '1;
        else if (pick < 85)
            v = (ws == WS_64) ? 64'h8000_0000_0000_0000 : {$urandom, 32'h8000_0000};
        else
            v = {$urandom, 28'd0, 4'($urandom_range(0, 15))};
        return v;
    endfunction

    function automatic beat_row_t random_row();
        beat_row_t   r;
        int unsigned pick;
        r = '0;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            r.cmd = CMD_MIX;
        else if (pick < 60)
            r.cmd = CMD_PACK;
        else if (pick < 92)
            r.cmd = CMD_SINGLE;
        else
            r.cmd = CMD_SPARE;
        if ($urandom_range(0, 6) == 0)
            r.count = 3'($urandom_range(0, 7));
        else
            r.count = 3'($urandom_range(2, 4));
        r.ws = 2'($urandom_range(0, 3));
        r.fm = 1'($urandom_range(0, 1));
        r.a  = random_operand(r.ws);
        r.b  = random_operand(r.ws);
        r.c  = random_operand(r.ws);
        r.d  = random_operand(r.ws);
        return r;
    endfunction

    function automatic int random_gap();
        int unsigned pick;
        int          g;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            g = 0;
        else if (pick < 90)
            g = $urandom_range(1, 3);
        else
            g = $urandom_range(8, 40);
        return g;
    endfunction

    // Drive one beat and return at the edge that takes it.
    task automatic send_beat(input beat_row_t row, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= row.cmd;
        operand_count <= row.count;
        word_size     <= row.ws;
        float_mode    <= row.fm;
        op_a          <= row.a;
        op_b          <= row.b;
        op_c          <= row.c;
        op_d          <= row.d;
        typed_on      <= row.typed;
        typed_want    <= row.want;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_hashes.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    initial
    begin
        int  burst_left;
        int  gap;
        logic tx_calm;
        burst_left = 0;
        tx_calm = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i], ($urandom_range(0, 3) == 0) ? 2 : 0);

        // let the pipe empty out completely before the random part
        in_valid <= 1'b0;
        wait_drained();

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i % 50 == 0)
                tx_calm = ($urandom_range(0, 3) == 0);
            if (i == RANDOM_BEATS / 2)
            begin
                // output holds off while beats keep coming: pipe and skid fill up
                hold_req <= 1'b1;
                burst_left = 80;
            end
            gap = (burst_left > 0 || tx_calm) ? 0 : random_gap();
            if (burst_left > 0)
                burst_left--;
            send_beat(random_row(), gap);
        end
        in_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("integer_mix_hash_unit_test passed");
        else
            $display("integer_mix_hash_unit_test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: short random stalls, calm stretches, one long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (cycle_count % 256 == 0)
            rx_calm <= ($urandom_range(0, 3) == 0);
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done  <= 1'b1;
            stall_left <= LONG_HOLD - 1;
            out_ready  <= 1'b0;
        end
        else if (rx_calm)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 65)
            begin
                out_ready <= 1'b1;
            end
            else if (rx_pick < 95)
            begin
                out_ready  <= 1'b0;
                stall_left <= $urandom_range(0, 2);
            end
            else
            begin
                out_ready  <= 1'b0;
                stall_left <= $urandom_range(8, 40);
            end
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: check the outgoing beat first, then queue the incoming one
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_hashes.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: hash_value beat with none expected, actual %h",
                             $time, hash_value);
                end
                else
                begin
                    want = pending_hashes.pop_front();
                    if (hash_value !== want)
                    begin
                        mismatch_count++;
                        $display("%0t: hash_value mismatch, expected %h, actual %h",
                                 $time, want, hash_value);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (typed_on)
                    want = typed_want;
                else
                    want = expected_hash(command, operand_count, ws_t'(word_size),
                                         float_mode, op_a, op_b, op_c, op_d);
                pending_hashes.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("integer_mix_hash_unit_test failed");
            $finish;
        end
    end

endmodule
`default_nettype wire

FILE: filelist.f
hdl/imhu_pkg.sv
hdl/imhu_load.sv
hdl/imhu_cell.sv
hdl/integer_mix_hash_unit.sv
tb/integer_mix_hash_unit_test.sv
